// ===== hw/rtl/tch_pkg.sv =====
// shared types, codes and constants for the transfer header checker
`default_nettype none

package tch_pkg;

    // default width of the file byte counter
    localparam int COUNT_BITS_DEF = 25;

    // fixed field widths
    localparam int BYTE_BITS  = 8;
    localparam int LEN_BITS   = 24;
    localparam int PCNT_BITS  = 25;
    localparam int OUT_TDATA_BITS = 40;

    // header lengths of the two formats
    localparam logic [4:0] HDR_LEN_A = 5'd27;
    localparam logic [4:0] HDR_LEN_B = 5'd16;

    // magic, type and trailer bytes
    localparam logic [7:0] MAGIC_A0   = 8'h01;
    localparam logic [7:0] MAGIC_A2   = 8'h43;
    localparam logic [7:0] MAGIC_A3   = 8'h4F;
    localparam logic [7:0] MAGIC_A4   = 8'h4D;
    localparam logic [7:0] TYPE_A     = 8'h40;
    localparam logic [7:0] MAGIC_B0   = 8'hFF;
    localparam logic [7:0] MAGIC_B1   = 8'h10;
    localparam logic [7:0] ZERO_BYTE  = 8'h00;
    localparam logic [7:0] TYPE_B     = 8'h21;
    localparam logic [7:0] TRAILER_B1 = 8'h0F;
    localparam logic [7:0] TRAILER_B2 = 8'hF0;

    // status codes on the final item
    typedef enum logic [2:0] {
        ST_OK_A        = 3'd0,
        ST_OK_B        = 3'd1,
        ST_BAD_TYPE    = 3'd2,
        ST_BAD_TRAILER = 3'd3,
        ST_BAD_LENGTH  = 3'd4,
        ST_UNKNOWN     = 3'd5
    } status_t;

    // format decision, one-hot
    typedef enum logic [3:0] {
        GUESS_NONE = 4'b0001,
        GUESS_A    = 4'b0010,
        GUESS_B    = 4'b0100,
        GUESS_BAD  = 4'b1000
    } guess_t;

    // one result item from the checker core
    typedef struct packed {
        logic                 has;
        logic                 byte_valid;
        logic [BYTE_BITS-1:0] payload_byte;
        logic                 status_valid;
        status_t              status;
        logic [PCNT_BITS-1:0] payload_count;
    } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tch_core.sv =====
// header decode, per-file state and result formation for one byte per cycle while accept is high
`default_nettype none

module tch_core #(
    parameter int COUNT_BITS = tch_pkg::COUNT_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire logic [tch_pkg::BYTE_BITS-1:0] file_byte,
    input  wire logic                          end_of_file,
    output tch_pkg::result_t                   res
);
    import tch_pkg::*;

    localparam int CMP_BITS = (COUNT_BITS + 1 > PCNT_BITS + 1) ? COUNT_BITS + 1 : PCNT_BITS + 1;

    logic [COUNT_BITS-1:0] count_reg, count_next;
    guess_t                guess_reg, guess_next;
    logic [LEN_BITS-1:0]   len_reg, len_next;
    logic                  type_reg, type_next;
    logic                  trailer_reg, trailer_next;

    logic                  sat;
    logic [4:0]            hdr;
    logic                  known;
    logic                  payload;
    logic [PCNT_BITS-1:0]  cnt;
    logic [CMP_BITS-1:0]   idx_plus;
    logic [CMP_BITS-1:0]   expect_len;
    logic                  hdr_done;
    logic                  len_ok;
    status_t               st;

    // header field capture for the current byte
    always_comb
    begin
        guess_next   = guess_reg;
        len_next     = len_reg;
        type_next    = type_reg;
        trailer_next = trailer_reg;
        if (count_reg == '0)
        begin
            if (file_byte == MAGIC_A0)
                guess_next = GUESS_A;
            else if (file_byte == MAGIC_B0)
                guess_next = GUESS_B;
            else
                guess_next = GUESS_BAD;
        end
        else
        begin
            case (guess_reg)
                GUESS_A:
                begin
                    if (count_reg == COUNT_BITS'(1))
                        type_next = (file_byte == TYPE_A);
                    else if (count_reg == COUNT_BITS'(2) && file_byte != MAGIC_A2)
                        guess_next = GUESS_BAD;
                    else if (count_reg == COUNT_BITS'(3) && file_byte != MAGIC_A3)
                        guess_next = GUESS_BAD;
                    else if (count_reg == COUNT_BITS'(4) && file_byte != MAGIC_A4)
                        guess_next = GUESS_BAD;
                    else if (count_reg == COUNT_BITS'(23))
                        len_next = {8'h00, file_byte, len_reg[7:0]};
                    else if (count_reg == COUNT_BITS'(24))
                        len_next = {8'h00, len_reg[15:8], file_byte};
                end
                GUESS_B:
                begin
                    if (count_reg == COUNT_BITS'(1) && file_byte != MAGIC_B1)
                        guess_next = GUESS_BAD;
                    else if ((count_reg == COUNT_BITS'(2) || count_reg == COUNT_BITS'(3))
                             && file_byte != ZERO_BYTE)
                        guess_next = GUESS_BAD;
                    else if (count_reg == COUNT_BITS'(4))
                        type_next = (file_byte == TYPE_B);
                    else if (count_reg == COUNT_BITS'(5))
                        len_next = {len_reg[23:8], file_byte};
                    else if (count_reg == COUNT_BITS'(6))
                        len_next = {len_reg[23:16], file_byte, len_reg[7:0]};
                    else if (count_reg == COUNT_BITS'(7))
                        len_next = {file_byte, len_reg[15:0]};
                    else if (count_reg == COUNT_BITS'(14))
                        trailer_next = (file_byte == ZERO_BYTE);
                    else if (count_reg == COUNT_BITS'(15))
                        trailer_next = trailer_reg
                            && (file_byte == TRAILER_B1 || file_byte == TRAILER_B2);
                end
                default:
                begin
                    guess_next = guess_reg;
                end
            endcase
        end
    end

    // payload detection and saturating count
    always_comb
    begin
        sat        = (count_reg == '1);
        count_next = sat ? count_reg : count_reg + COUNT_BITS'(1);
        known      = (guess_next == GUESS_A) || (guess_next == GUESS_B);
        hdr        = (guess_next == GUESS_A) ? HDR_LEN_A : HDR_LEN_B;
        payload    = known && (count_reg >= COUNT_BITS'(hdr));
    end

    // length check and status on the final byte
    always_comb
    begin
        if (guess_next == GUESS_A)
            cnt = PCNT_BITS'(len_next[15:0]) + PCNT_BITS'(1);
        else
            cnt = PCNT_BITS'(len_next);
        idx_plus   = CMP_BITS'(count_reg) + CMP_BITS'(1);
        expect_len = CMP_BITS'(hdr) + CMP_BITS'(cnt);
        hdr_done   = idx_plus >= CMP_BITS'(hdr);
        len_ok     = !sat && (idx_plus == expect_len);
        if (!(known && hdr_done))
            st = ST_UNKNOWN;
        else if (!type_next)
            st = ST_BAD_TYPE;
        else if (guess_next == GUESS_B && !trailer_next)
            st = ST_BAD_TRAILER;
        else if (!len_ok)
            st = ST_BAD_LENGTH;
        else if (guess_next == GUESS_A)
            st = ST_OK_A;
        else
            st = ST_OK_B;
    end

    // result item
    always_comb
    begin
        res.has           = payload || end_of_file;
        res.byte_valid    = payload;
        res.payload_byte  = payload ? file_byte : '0;
        res.status_valid  = end_of_file;
        res.status        = end_of_file ? st : ST_OK_A;
        res.payload_count = (end_of_file && st != ST_UNKNOWN) ? cnt : '0;
    end

    // per-file state, cleared after the final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            guess_reg   <= GUESS_NONE;
            len_reg     <= '0;
            type_reg    <= 1'b0;
            trailer_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (end_of_file)
            begin
                count_reg   <= '0;
                guess_reg   <= GUESS_NONE;
                len_reg     <= '0;
                type_reg    <= 1'b0;
                trailer_reg <= 1'b0;
            end
            else
            begin
                count_reg   <= count_next;
                guess_reg   <= guess_next;
                len_reg     <= len_next;
                type_reg    <= type_next;
                trailer_reg <= trailer_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/transfer_header_checker_top.sv =====
// top level of the transfer header checker: checker core and output skid stage
//
//  channel | dir | tdata (low bit up)                          | tuser      | tlast
//  s_axis  | in  | file_byte[7:0]                              | -          | end_of_file
//  m_axis  | out | payload_byte[7:0] status[10:8] count[35:11] | byte_valid | status_valid
//
// one input item per cycle while s_axis_tready is high; a result is registered in the output stage before it leaves
// the per-byte decode sits between the input port and a two-entry output stage
// reset clears the file state and empties the output stage
// s_axis_tready drops only while both output entries are full
`default_nettype none

module transfer_header_checker_top #(
    parameter int COUNT_BITS = tch_pkg::COUNT_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [7:0]                         s_axis_tdata,   // file_byte
    input  wire logic                               s_axis_tlast,   // end_of_file
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [tch_pkg::OUT_TDATA_BITS-1:0]      m_axis_tdata,   // payload_byte, status,
                                                                    // payload_count, zero pad
    output logic                                    m_axis_tuser,   // byte_valid
    output logic                                    m_axis_tlast    // status_valid
);
    import tch_pkg::*;

    localparam int PAD_BITS = OUT_TDATA_BITS - BYTE_BITS - 3 - PCNT_BITS;

    logic    in_accept;
    result_t res;
    logic    push;
    logic    pop;

    logic    out_valid_reg;
    result_t out_data_reg;
    logic    skid_valid_reg;
    result_t skid_data_reg;

    assign s_axis_tready = !skid_valid_reg;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    tch_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_accept),
        .file_byte   (s_axis_tdata),
        .end_of_file (s_axis_tlast),
        .res         (res)
    );

    assign push = in_accept && res.has;
    assign pop  = out_valid_reg && m_axis_tready;

    // output register with one skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // payload of the output stage
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_data_reg <= skid_data_reg;
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
                out_data_reg <= res;
            else
                skid_data_reg <= res;
        end
    end

    // master-side packing
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_data_reg.byte_valid;
    assign m_axis_tlast  = out_data_reg.status_valid;
    assign m_axis_tdata  = {{PAD_BITS{1'b0}}, out_data_reg.payload_count,
                            out_data_reg.status, out_data_reg.payload_byte};

endmodule

`default_nettype wire

// ===== hw/rtl/tch_checker.sv =====
// port-level assertions for the transfer header checker and their binding
`default_nettype none

module tch_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               s_axis_tvalid,
    input wire logic                               s_axis_tready,
    input wire logic [7:0]                         s_axis_tdata,
    input wire logic                               s_axis_tlast,
    input wire logic                               m_axis_tvalid,
    input wire logic                               m_axis_tready,
    input wire logic [tch_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,
    input wire logic                               m_axis_tuser,
    input wire logic                               m_axis_tlast
);
    import tch_pkg::*;

    // every result item is a payload byte or a final status
    a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser || m_axis_tlast))
        else $error("result item is neither payload nor status");

    // status fields stay zero away from the final item
    a_status_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[35:8] == '0))
        else $error("status fields set on a non-final item");

    // payload byte is zero when no payload is carried
    a_payload_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[7:0] == 8'h00))
        else $error("payload byte set without byte_valid");

    // unrecognized files report no count
    a_unknown_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast && m_axis_tdata[10:8] == ST_UNKNOWN)
        |-> (m_axis_tdata[35:11] == '0))
        else $error("count reported on an unrecognized file");

    // a stalled result stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped while stalled");

endmodule

bind transfer_header_checker_top tch_checker u_tch_checker (.*);

`default_nettype wire
